// ----- hdl/draw_list_payload_parser_macros.svh -----
// Assertion macros used by the checker file of the draw-list payload parser.
`ifndef DRAW_LIST_PAYLOAD_PARSER_MACROS_SVH
`define DRAW_LIST_PAYLOAD_PARSER_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define DLPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlpp check failed");

// Check the consequent in the cycle after the antecedent.
`define DLPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlpp check failed");

`endif

// ----- hdl/dlpp_pkg.sv -----
// Types, codes and constants of the draw-list payload parser.
`timescale 1ns / 1ps
`default_nettype none

package dlpp_pkg;

  localparam int LIST_CAPACITY = 32;
  localparam int QueueDepth    = 4;
  localparam int QPtrWidth     = $clog2(QueueDepth);
  localparam int CfgIndexWidth = 3;
  localparam int ReasonWidth   = 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_FIELDS,
    PH_STRING,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    K_RECORD = 2'd0,
    K_WRITE  = 2'd1,
    K_ACCEPT = 2'd2,
    K_REJECT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    T_TEXT   = 3'd0,
    T_CLOCK  = 3'd1,
    T_HAND   = 3'd2,
    T_LINE   = 3'd3,
    T_CIRCLE = 3'd4
  } item_type_e;

  typedef enum logic [ReasonWidth-1:0] {
    R_LIST_LONG = 3'd0,
    R_TRUNC     = 3'd1,
    R_ARENA     = 3'd2,
    R_HAND_SRC  = 3'd3,
    R_TAG       = 3'd4,
    R_NO_ARENA  = 3'd5
  } reason_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_TEXT_TAG   = 3'd0,
    CFG_CLOCK_TAG  = 3'd1,
    CFG_HAND_TAG   = 3'd2,
    CFG_LINE_TAG   = 3'd3,
    CFG_CIRCLE_TAG = 3'd4,
    CFG_ARENA_CAP  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [15:0] payload_length;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [2:0]         item_type;
    logic signed [15:0] coord_a;
    logic signed [15:0] coord_b;
    logic signed [15:0] coord_c;
    logic signed [15:0] coord_d;
    logic [15:0]        address;
    logic [7:0]         text_length;
    logic [7:0]         value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  item_type;
    logic [15:0] coord_a;
    logic [15:0] coord_b;
    logic [15:0] coord_c;
    logic [15:0] coord_d;
    logic [15:0] address;
    logic [7:0]  text_length;
    logic [7:0]  value;
  } rec_t;

  // mask bit 0: string byte write, 1: terminating zero, 2: record, 3: status
  typedef struct packed {
    logic [3:0]  mask;
    logic [15:0] wr_byte_addr;
    logic [7:0]  wr_byte_val;
    logic [15:0] wr_zero_addr;
    rec_t        rec;
    logic        status_ok;
    reason_e     reason;
  } job_t;

endpackage

`default_nettype wire

// ----- hdl/dlpp_front.sv -----
// Front end: byte intake, configuration registers and parse state.
`timescale 1ns / 1ps
`default_nettype none

module dlpp_front import dlpp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_data_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  input  logic                     queue_full_i,
  output logic                     push_o,
  output job_t                     push_data_o
);

  logic [7:0]  text_tag_q, clock_tag_q, hand_tag_q, line_tag_q, circle_tag_q;
  logic [15:0] arena_cap_q;

  phase_e           phase_q, phase_d;
  logic [3:0]       fidx_q, fidx_d;
  logic [2:0]       type_q, type_d;
  logic [3:0][15:0] coord_q, coord_d;
  logic [7:0]       slen_q, slen_d;
  logic [7:0]       sidx_q, sidx_d;
  logic [15:0]      base_q, base_d;
  logic [15:0]      bytes_left_q, bytes_left_d;
  logic [7:0]       items_left_q, items_left_d;
  logic [15:0]      arena_used_q, arena_used_d;

  logic        acc;
  logic [7:0]  byte_v;
  logic [15:0] bl_dec;
  logic        tag_hit;
  logic [2:0]  tag_type;
  logic [3:0]  need;
  logic [3:0]  nc;
  logic [16:0] arena_sum;

  logic        do_status, status_ok;
  reason_e     status_reason;
  logic        do_item_done, go_string;
  logic [7:0]  item_val;
  logic        do_wr_byte, do_wr_zero;
  logic [15:0] wr_byte_addr, wr_zero_addr;
  logic        wide_type, str_type;

  assign in_ready_o  = !queue_full_i;
  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i && in_ready_o;
  assign byte_v      = in_data_i.data_byte;
  assign bl_dec      = bytes_left_q - 16'd1;
  assign arena_sum   = {1'b0, arena_used_q} + {9'b0, byte_v} + 17'd1;
  assign wide_type   = (type_q == T_HAND) || (type_q == T_LINE);
  assign str_type    = (type_q == T_TEXT) || (type_q == T_CLOCK);
  assign nc          = wide_type ? 4'd8 : 4'd6;

  always_comb begin
    tag_hit  = 1'b1;
    tag_type = T_TEXT;
    if (byte_v == text_tag_q) begin
      tag_type = T_TEXT;
    end else if (byte_v == clock_tag_q) begin
      tag_type = T_CLOCK;
    end else if (byte_v == hand_tag_q) begin
      tag_type = T_HAND;
    end else if (byte_v == line_tag_q) begin
      tag_type = T_LINE;
    end else if (byte_v == circle_tag_q) begin
      tag_type = T_CIRCLE;
    end else begin
      tag_hit = 1'b0;
    end
    case (tag_type)
      T_TEXT, T_CLOCK: need = 4'd7;
      T_HAND:          need = 4'd9;
      T_LINE:          need = 4'd8;
      default:         need = 4'd6;
    endcase
  end

  // Parse datapath and result decisions
  always_comb begin
    fidx_d        = fidx_q;
    type_d        = type_q;
    coord_d       = coord_q;
    slen_d        = slen_q;
    sidx_d        = sidx_q;
    base_d        = base_q;
    bytes_left_d  = bytes_left_q;
    items_left_d  = items_left_q;
    arena_used_d  = arena_used_q;
    do_status     = 1'b0;
    status_ok     = 1'b0;
    status_reason = R_LIST_LONG;
    do_item_done  = 1'b0;
    go_string     = 1'b0;
    item_val      = 8'd0;
    do_wr_byte    = 1'b0;
    do_wr_zero    = 1'b0;
    wr_byte_addr  = 16'd0;
    wr_zero_addr  = 16'd0;
    if (acc) begin
      if (in_data_i.first) begin
        fidx_d       = 4'd0;
        type_d       = T_TEXT;
        coord_d      = '0;
        slen_d       = 8'd0;
        sidx_d       = 8'd0;
        base_d       = 16'd0;
        items_left_d = 8'd0;
        arena_used_d = 16'd0;
        bytes_left_d = 16'd0;
        if (in_data_i.payload_length == 16'd0) begin
          do_status     = 1'b1;
          status_reason = R_TRUNC;
        end else if (arena_cap_q == 16'd0) begin
          do_status     = 1'b1;
          status_reason = R_NO_ARENA;
        end else begin
          bytes_left_d = in_data_i.payload_length - 16'd1;
          if (byte_v > 8'(LIST_CAPACITY)) begin
            do_status     = 1'b1;
            status_reason = R_LIST_LONG;
          end else if (byte_v == 8'd0) begin
            do_status = 1'b1;
            status_ok = 1'b1;
          end else if (bytes_left_d == 16'd0) begin
            do_status     = 1'b1;
            status_reason = R_TRUNC;
          end else begin
            items_left_d = byte_v;
          end
        end
      end else begin
        case (phase_q)
          PH_TAG: begin
            bytes_left_d = bl_dec;
            if (!tag_hit) begin
              do_status     = 1'b1;
              status_reason = R_TAG;
            end else begin
              type_d = tag_type;
              if (bl_dec < {12'd0, need}) begin
                do_status     = 1'b1;
                status_reason = R_TRUNC;
              end else begin
                coord_d = '0;
                fidx_d  = 4'd0;
              end
            end
          end
          PH_FIELDS: begin
            bytes_left_d = bl_dec;
            if (fidx_q < nc) begin
              if (fidx_q[0]) begin
                coord_d[fidx_q[2:1]][15:8] = byte_v;
              end else begin
                coord_d[fidx_q[2:1]][7:0] = byte_v;
              end
              fidx_d = fidx_q + 4'd1;
              if ((fidx_d == nc) && (type_q >= T_LINE)) begin
                do_item_done = 1'b1;
              end
            end else if (type_q == T_HAND) begin
              if (byte_v > 8'd2) begin
                do_status     = 1'b1;
                status_reason = R_HAND_SRC;
              end else begin
                do_item_done = 1'b1;
                item_val     = byte_v;
              end
            end else begin
              if (bl_dec < {8'd0, byte_v}) begin
                do_status     = 1'b1;
                status_reason = R_TRUNC;
              end else if (arena_sum > {1'b0, arena_cap_q}) begin
                do_status     = 1'b1;
                status_reason = R_ARENA;
              end else begin
                base_d       = arena_used_q;
                arena_used_d = arena_sum[15:0];
                slen_d       = byte_v;
                sidx_d       = 8'd0;
                if (byte_v == 8'd0) begin
                  do_wr_zero   = 1'b1;
                  wr_zero_addr = arena_used_q;
                  do_item_done = 1'b1;
                end else begin
                  go_string = 1'b1;
                end
              end
            end
          end
          PH_STRING: begin
            bytes_left_d = bl_dec;
            do_wr_byte   = 1'b1;
            wr_byte_addr = base_q + {8'd0, sidx_q};
            sidx_d       = sidx_q + 8'd1;
            if (sidx_d == slen_q) begin
              do_wr_zero   = 1'b1;
              wr_zero_addr = base_q + {8'd0, slen_q};
              do_item_done = 1'b1;
            end
          end
          default: ;
        endcase
        if (do_item_done) begin
          items_left_d = items_left_q - 8'd1;
          if (items_left_d == 8'd0) begin
            do_status = 1'b1;
            status_ok = 1'b1;
          end else if (bytes_left_d == 16'd0) begin
            do_status     = 1'b1;
            status_reason = R_TRUNC;
          end
        end
      end
    end
  end

  // Next parse phase
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      if (do_status) begin
        phase_d = PH_DONE;
      end else if (in_data_i.first || do_item_done) begin
        phase_d = PH_TAG;
      end else begin
        case (phase_q)
          PH_TAG:    phase_d = PH_FIELDS;
          PH_FIELDS: if (go_string) phase_d = PH_STRING;
          default:   ;
        endcase
      end
    end
  end

  // Job for the back end
  always_comb begin
    push_data_o                  = '0;
    push_data_o.mask             = {do_status, do_item_done, do_wr_zero, do_wr_byte};
    push_data_o.wr_byte_addr     = wr_byte_addr;
    push_data_o.wr_byte_val      = byte_v;
    push_data_o.wr_zero_addr     = wr_zero_addr;
    push_data_o.rec.item_type    = type_q;
    push_data_o.rec.coord_a      = coord_d[0];
    push_data_o.rec.coord_b      = coord_d[1];
    push_data_o.rec.coord_c      = coord_d[2];
    push_data_o.rec.coord_d      = wide_type ? coord_d[3] : 16'd0;
    push_data_o.rec.address      = str_type ? base_d : 16'd0;
    push_data_o.rec.text_length  = str_type ? slen_d : 8'd0;
    push_data_o.rec.value        = item_val;
    push_data_o.status_ok        = status_ok;
    push_data_o.reason           = status_reason;
    push_o = acc && (do_status || do_item_done || do_wr_zero || do_wr_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_tag_q   <= 8'd0;
      clock_tag_q  <= 8'd1;
      hand_tag_q   <= 8'd2;
      line_tag_q   <= 8'd3;
      circle_tag_q <= 8'd4;
      arena_cap_q  <= 16'd1024;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TEXT_TAG:   text_tag_q   <= cfg_data_i[7:0];
        CFG_CLOCK_TAG:  clock_tag_q  <= cfg_data_i[7:0];
        CFG_HAND_TAG:   hand_tag_q   <= cfg_data_i[7:0];
        CFG_LINE_TAG:   line_tag_q   <= cfg_data_i[7:0];
        CFG_CIRCLE_TAG: circle_tag_q <= cfg_data_i[7:0];
        CFG_ARENA_CAP:  arena_cap_q  <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      fidx_q       <= 4'd0;
      type_q       <= T_TEXT;
      coord_q      <= '0;
      slen_q       <= 8'd0;
      sidx_q       <= 8'd0;
      base_q       <= 16'd0;
      bytes_left_q <= 16'd0;
      items_left_q <= 8'd0;
      arena_used_q <= 16'd0;
    end else begin
      phase_q      <= phase_d;
      fidx_q       <= fidx_d;
      type_q       <= type_d;
      coord_q      <= coord_d;
      slen_q       <= slen_d;
      sidx_q       <= sidx_d;
      base_q       <= base_d;
      bytes_left_q <= bytes_left_d;
      items_left_q <= items_left_d;
      arena_used_q <= arena_used_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dlpp_fifo.sv -----
// Job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module dlpp_fifo import dlpp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o
);

  job_t                 mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrWidth:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (QPtrWidth+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrWidth'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QPtrWidth+1)'(1);
        2'b01:   count_q <= count_q - (QPtrWidth+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dlpp_back.sv -----
// Back end: expand queued jobs into results through an output register.
`timescale 1ns / 1ps
`default_nettype none

module dlpp_back import dlpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  job_t       cur_q, sel_job;
  logic [3:0] mask_q, sel_mask, pick, rest;
  logic       use_head, out_free, fire;
  out_item_t  out_q;
  logic       out_valid_q;

  function automatic out_item_t make_result(job_t j, logic [3:0] sel, logic fin);
    out_item_t r;
    r = '0;
    if (sel[0]) begin
      r.kind    = K_WRITE;
      r.address = j.wr_byte_addr;
      r.value   = j.wr_byte_val;
    end else if (sel[1]) begin
      r.kind    = K_WRITE;
      r.address = j.wr_zero_addr;
    end else if (sel[2]) begin
      r.kind        = K_RECORD;
      r.item_type   = j.rec.item_type;
      r.coord_a     = j.rec.coord_a;
      r.coord_b     = j.rec.coord_b;
      r.coord_c     = j.rec.coord_c;
      r.coord_d     = j.rec.coord_d;
      r.address     = j.rec.address;
      r.text_length = j.rec.text_length;
      r.value       = j.rec.value;
    end else begin
      r.kind  = j.status_ok ? K_ACCEPT : K_REJECT;
      r.value = j.status_ok ? 8'd0 : {{(8-ReasonWidth){1'b0}}, j.reason};
    end
    r.last = fin;
    return r;
  endfunction

  always_comb begin
    use_head = (mask_q == 4'd0);
    sel_job  = use_head ? head_i : cur_q;
    sel_mask = use_head ? (empty_i ? 4'd0 : head_i.mask) : mask_q;
    out_free = !out_valid_q || out_ready_i;
    fire     = out_free && (sel_mask != 4'd0);
    pick     = sel_mask & (~sel_mask + 4'd1);
    rest     = sel_mask & ~pick;
    pop_o    = fire && use_head;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else if (fire) begin
      mask_q      <= rest;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cur_q <= sel_job;
      out_q <= make_result(sel_job, pick, rest == 4'd0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/draw_list_payload_parser.sv -----
// Top level of the draw-list payload parser.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   in       | in_valid_i / in_ready_o   | in_data_i   (data_byte, first, length)
//   out      | out_valid_o / out_ready_i | out_data_o  (kind .. last)
//   cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The front end parses one byte per cycle while its four-entry job queue is not full and
// hands its results to that queue; the back end emits one result per cycle unless
// out_ready_i holds it; a byte yields no result or up to four, four only at a string end.
// in_ready_o drops only while the job queue is full; cfg_ready_o is always high.
// Reset is asynchronous and active low; no clearing pass follows it.
`timescale 1ns / 1ps
`default_nettype none

module draw_list_payload_parser import dlpp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [15:0]              cfg_data_i
);

  logic push, full, pop, empty;
  job_t push_data, head;

  dlpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  dlpp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  dlpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hdl/dlpp_checker.sv -----
// Port-level checks of the draw-list payload parser and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "draw_list_payload_parser_macros.svh"

module dlpp_checker import dlpp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic is_status;
  logic is_plain_rec;

  assign is_status    = out_valid_o &&
                        (out_data_o.kind == K_ACCEPT || out_data_o.kind == K_REJECT);
  assign is_plain_rec = out_valid_o && out_data_o.kind == K_RECORD &&
                        out_data_o.item_type != T_TEXT && out_data_o.item_type != T_CLOCK;

  `DLPP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `DLPP_ASSERT_NOW(a_status_last, is_status, out_data_o.last && out_data_o.item_type == T_TEXT)
  `DLPP_ASSERT_NOW(a_shape_rec, is_plain_rec, out_data_o.address == '0 && out_data_o.text_length == '0)
  `DLPP_ASSERT_NOW(a_reason, out_valid_o && out_data_o.kind == K_REJECT, out_data_o.value <= 8'(R_NO_ARENA))

endmodule

bind draw_list_payload_parser dlpp_checker u_checker (.*);

`default_nettype wire

// ----- bench/draw_list_payload_parser_test.sv -----
// Self-checking testbench for the draw-list payload parser: directed and random payloads against a predictor.
`timescale 1ns / 1ps

module draw_list_payload_parser_test;
  import dlpp_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 10;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  in_item_t                 in_data_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  out_item_t                out_data_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [15:0]              cfg_data_i;

  // predictor configuration and parse state
  logic [7:0]  tag_code [5];
  logic [15:0] arena_cap;
  phase_e      parse_ph;
  logic [3:0]  field_idx;
  item_type_e  item_kind;
  logic [15:0] coord_reg [4];
  logic [7:0]  str_len;
  logic [7:0]  str_pos;
  logic [15:0] str_base;
  logic [15:0] bytes_left;
  logic [7:0]  items_left;
  logic [15:0] arena_used;

  out_item_t   pending_results [$];
  out_item_t   byte_results [$];
  logic [7:0]  payload [$];
  int          payload_bytes;
  int          failures;
  int          quiet_cycles;
  int          tx_calm;
  int          rx_calm;

  draw_list_payload_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic reset_model();
    tag_code[T_TEXT]   = 8'd0;
    tag_code[T_CLOCK]  = 8'd1;
    tag_code[T_HAND]   = 8'd2;
    tag_code[T_LINE]   = 8'd3;
    tag_code[T_CIRCLE] = 8'd4;
    arena_cap  = 16'd1024;
    parse_ph   = PH_IDLE;
    field_idx  = '0;
    item_kind  = T_TEXT;
    coord_reg  = '{default: '0};
    str_len    = '0;
    str_pos    = '0;
    str_base   = '0;
    bytes_left = '0;
    items_left = '0;
    arena_used = '0;
  endtask

  task automatic apply_register(cfg_idx_e idx, logic [15:0] data);
    case (idx)
      CFG_TEXT_TAG:   tag_code[T_TEXT]   = data[7:0];
      CFG_CLOCK_TAG:  tag_code[T_CLOCK]  = data[7:0];
      CFG_HAND_TAG:   tag_code[T_HAND]   = data[7:0];
      CFG_LINE_TAG:   tag_code[T_LINE]   = data[7:0];
      CFG_CIRCLE_TAG: tag_code[T_CIRCLE] = data[7:0];
      CFG_ARENA_CAP:  arena_cap          = data;
      default: ;
    endcase
  endtask

  task automatic emit(kind_e k, logic [2:0] t, logic [15:0] a, logic [15:0] b,
                      logic [15:0] c, logic [15:0] d, logic [15:0] addr,
                      logic [7:0] len, logic [7:0] val);
    out_item_t r;
    r.kind        = k;
    r.item_type   = t;
    r.coord_a     = a;
    r.coord_b     = b;
    r.coord_c     = c;
    r.coord_d     = d;
    r.address     = addr;
    r.text_length = len;
    r.value       = val;
    r.last        = 1'b0;
    byte_results.push_back(r);
  endtask

  task automatic accept_payload();
    emit(K_ACCEPT, '0, '0, '0, '0, '0, '0, '0, '0);
    parse_ph = PH_DONE;
  endtask

  task automatic reject_payload(reason_e why);
    emit(K_REJECT, '0, '0, '0, '0, '0, '0, '0, 8'(why));
    parse_ph = PH_DONE;
  endtask

  task automatic close_item(logic [7:0] src);
    case (item_kind)
      T_TEXT, T_CLOCK:
        emit(K_RECORD, item_kind, coord_reg[0], coord_reg[1], coord_reg[2], '0,
             str_base, str_len, '0);
      T_HAND:
        emit(K_RECORD, T_HAND, coord_reg[0], coord_reg[1], coord_reg[2], coord_reg[3],
             '0, '0, src);
      T_LINE:
        emit(K_RECORD, T_LINE, coord_reg[0], coord_reg[1], coord_reg[2], coord_reg[3],
             '0, '0, '0);
      default:
        emit(K_RECORD, T_CIRCLE, coord_reg[0], coord_reg[1], coord_reg[2], '0,
             '0, '0, '0);
    endcase
    items_left = items_left - 8'd1;
    if (items_left == 0) accept_payload();
    else if (bytes_left == 0) reject_payload(R_TRUNC);
    else parse_ph = PH_TAG;
  endtask

  task automatic decode_byte(in_item_t it);
    logic [7:0] b;
    logic [3:0] need;
    logic [3:0] nc;
    bit         known;
    b = it.data_byte;
    byte_results.delete();
    if (it.first) begin
      field_idx  = '0;
      item_kind  = T_TEXT;
      coord_reg  = '{default: '0};
      str_len    = '0;
      str_pos    = '0;
      str_base   = '0;
      items_left = '0;
      arena_used = '0;
      bytes_left = '0;
      if (it.payload_length == 0) reject_payload(R_TRUNC);
      else if (arena_cap == 0) reject_payload(R_NO_ARENA);
      else begin
        bytes_left = it.payload_length - 16'd1;
        if (b > LIST_CAPACITY) reject_payload(R_LIST_LONG);
        else if (b == 0) accept_payload();
        else if (bytes_left == 0) reject_payload(R_TRUNC);
        else begin
          items_left = b;
          parse_ph   = PH_TAG;
        end
      end
    end else if (parse_ph == PH_TAG) begin
      bytes_left = bytes_left - 16'd1;
      known = 1'b1;
      if (b == tag_code[T_TEXT]) item_kind = T_TEXT;
      else if (b == tag_code[T_CLOCK]) item_kind = T_CLOCK;
      else if (b == tag_code[T_HAND]) item_kind = T_HAND;
      else if (b == tag_code[T_LINE]) item_kind = T_LINE;
      else if (b == tag_code[T_CIRCLE]) item_kind = T_CIRCLE;
      else begin
        known = 1'b0;
        reject_payload(R_TAG);
      end
      if (known) begin
        case (item_kind)
          T_TEXT, T_CLOCK: need = 4'd7;
          T_HAND:          need = 4'd9;
          T_LINE:          need = 4'd8;
          default:         need = 4'd6;
        endcase
        if (bytes_left < need) reject_payload(R_TRUNC);
        else begin
          coord_reg = '{default: '0};
          field_idx = '0;
          parse_ph  = PH_FIELDS;
        end
      end
    end else if (parse_ph == PH_FIELDS) begin
      bytes_left = bytes_left - 16'd1;
      nc = (item_kind == T_HAND || item_kind == T_LINE) ? 4'd8 : 4'd6;
      if (field_idx < nc) begin
        if (field_idx[0]) coord_reg[field_idx[2:1]][15:8] = b;
        else coord_reg[field_idx[2:1]][7:0] = b;
        field_idx = field_idx + 4'd1;
        if (field_idx == nc && item_kind >= T_LINE) close_item('0);
      end else if (item_kind == T_HAND) begin
        if (b > 8'd2) reject_payload(R_HAND_SRC);
        else close_item(b);
      end else if (bytes_left < b) begin
        reject_payload(R_TRUNC);
      end else if (int'(arena_used) + int'(b) + 1 > int'(arena_cap)) begin
        reject_payload(R_ARENA);
      end else begin
        str_base   = arena_used;
        arena_used = arena_used + b + 16'd1;
        str_len    = b;
        str_pos    = '0;
        if (b == 0) begin
          emit(K_WRITE, '0, '0, '0, '0, '0, str_base, '0, '0);
          close_item('0);
        end else begin
          parse_ph = PH_STRING;
        end
      end
    end else if (parse_ph == PH_STRING) begin
      bytes_left = bytes_left - 16'd1;
      emit(K_WRITE, '0, '0, '0, '0, '0, str_base + str_pos, '0, b);
      str_pos = str_pos + 8'd1;
      if (str_pos == str_len) begin
        emit(K_WRITE, '0, '0, '0, '0, '0, str_base + str_len, '0, '0);
        close_item('0);
      end
    end
    if (byte_results.size() > 0) begin
      byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[k]) pending_results.push_back(byte_results[k]);
    end
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: kind %0d value 0x%0h", got.kind, got.value);
      failures++;
    end else begin
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("item_type", want.item_type, got.item_type);
      compare_field("coord_a", want.coord_a, got.coord_a);
      compare_field("coord_b", want.coord_b, got.coord_b);
      compare_field("coord_c", want.coord_c, got.coord_c);
      compare_field("coord_d", want.coord_d, got.coord_d);
      compare_field("address", want.address, got.address);
      compare_field("text_length", want.text_length, got.text_length);
      compare_field("value", want.value, got.value);
      compare_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_register(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && in_ready_o) decode_byte(in_data_i);
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("draw_list_payload_parser verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = draw_gap(rx_calm);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic f, logic [15:0] len);
    int       gap;
    in_item_t it;
    gap = draw_gap(tx_calm);
    it.data_byte      = b;
    it.first          = f;
    it.payload_length = len;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [15:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_word(logic [15:0] w);
    payload.push_back(w[7:0]);
    payload.push_back(w[15:8]);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item(item_type_e t, int text_len, logic [7:0] src);
    payload.push_back(tag_code[t]);
    repeat ((t == T_HAND || t == T_LINE) ? 4 : 3) add_word(pick_coord());
    if (t <= T_CLOCK) begin
      payload.push_back(8'(text_len));
      repeat (text_len) payload.push_back(8'($urandom));
    end else if (t == T_HAND) begin
      payload.push_back(src);
    end
  endtask

  task automatic send_payload(logic [15:0] plen, int stray);
    foreach (payload[k]) send_byte(payload[k], k == 0, (k == 0) ? plen : 16'($urandom));
    repeat (stray) send_byte(8'($urandom), 1'b0, 16'($urandom));
    payload_bytes += payload.size();
    payload.delete();
  endtask

  task automatic random_payload();
    int          n_items;
    int          count;
    int          r;
    int          stray;
    logic [15:0] plen;
    logic [7:0]  src;
    n_items = ($urandom_range(0, 99) < 4) ? $urandom_range(6, 12) : $urandom_range(1, 4);
    count   = n_items;
    payload.push_back(8'd0);
    for (int i = 0; i < n_items; i++) begin
      src = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 255)) : 8'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 3) payload.push_back(8'($urandom));
      else add_item(item_type_e'($urandom_range(0, 4)), $urandom_range(0, 6), src);
    end
    r = $urandom_range(0, 99);
    if (r < 3) count = $urandom_range(LIST_CAPACITY + 1, 255);
    else if (r < 6) count = LIST_CAPACITY;
    else if (r < 12) count = n_items + $urandom_range(1, 2);
    else if (r < 15) count = $urandom_range(0, n_items - 1);
    payload[0] = 8'(count);
    r = $urandom_range(0, 99);
    if (r < 10) plen = 16'($urandom_range(1, payload.size()));
    else if (r < 15) plen = 16'(payload.size() + $urandom_range(1, 64));
    else plen = 16'(payload.size());
    stray = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    // drop the tail so that the next payload restarts the parse
    if ($urandom_range(0, 99) < 5 && payload.size() > 1)
      repeat ($urandom_range(1, payload.size() - 1)) void'(payload.pop_back());
    send_payload(plen, stray);
  endtask

  task automatic random_run(int goal);
    goal += payload_bytes;
    while (payload_bytes < goal) begin
      random_payload();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  task automatic test_edge_payloads();
    payload.push_back(8'd1);
    send_payload(16'd0, 0);
    payload.push_back(8'd0);
    send_payload(16'd1, 1);
    payload.push_back(8'(LIST_CAPACITY + 1));
    send_payload(16'd40, 0);
    payload.push_back(8'(LIST_CAPACITY));
    send_payload(16'd1, 0);
    payload = '{8'd1, 8'hee};
    send_payload(16'd2, 0);
    payload = '{8'd3, tag_code[T_CIRCLE], 8'h55};
    send_payload(16'd500, 0);
    payload.push_back(8'd1);
    payload.push_back(tag_code[T_LINE]);
    add_word(16'h8000);
    add_word(16'h7fff);
    add_word(16'hffff);
    add_word(16'h0000);
    send_payload(16'd10, 0);
  endtask

  task automatic test_default_tags();
    random_run(50);
  endtask

  task automatic test_moved_tags();
    write_register(CFG_TEXT_TAG, 16'h00ff);
    write_register(CFG_CLOCK_TAG, 16'h0080);
    write_register(CFG_HAND_TAG, 16'h0000);
    write_register(CFG_LINE_TAG, 16'h007f);
    write_register(CFG_CIRCLE_TAG, 16'h002a);
    write_register(CFG_ARENA_CAP, 16'hffff);
    payload.push_back(8'd2);
    add_item(T_CLOCK, 130, '0);
    add_item(T_HAND, 0, 8'd2);
    send_payload(16'(payload.size()), 0);
    random_run(20);
  endtask

  task automatic test_arena_limits();
    write_register(CFG_ARENA_CAP, 16'd0);
    payload.push_back(8'd0);
    send_payload(16'd1, 0);
    random_payload();
    write_register(CFG_ARENA_CAP, 16'($urandom_range(1, 16)));
    random_run(35);
  endtask

  task automatic test_shared_tags();
    write_register(CFG_TEXT_TAG, 16'h0010);
    write_register(CFG_CLOCK_TAG, 16'h0010);
    write_register(CFG_HAND_TAG, 16'h0020);
    write_register(CFG_LINE_TAG, 16'h0020);
    write_register(CFG_CIRCLE_TAG, 16'h0030);
    write_register(CFG_ARENA_CAP, 16'd1024);
    random_run(25);
  endtask

  task automatic test_restored_tags();
    write_register(CFG_TEXT_TAG, 16'd0);
    write_register(CFG_CLOCK_TAG, 16'd1);
    write_register(CFG_HAND_TAG, 16'd2);
    write_register(CFG_LINE_TAG, 16'd3);
    write_register(CFG_CIRCLE_TAG, 16'd4);
    write_register(CFG_ARENA_CAP, 16'($urandom_range(200, 2000)));
    random_run(25);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    failures      = 0;
    quiet_cycles  = 0;
    payload_bytes = 0;
    tx_calm       = 0;
    rx_calm       = 0;
    reset_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_edge_payloads();
    test_default_tags();
    test_moved_tags();
    test_arena_limits();
    test_shared_tags();
    test_restored_tags();
    wait_drained();
    if (failures == 0 && pending_results.size() == 0) begin
      $display("draw_list_payload_parser verification clean");
    end else begin
      $display("draw_list_payload_parser verification failed");
    end
    $finish;
  end

endmodule
